/* hdl/sps_pkg.sv */
// Shared types, widths and register codes for the softened potential sum block.
package sps_pkg;

	// Number formats
	localparam int COORD_FRAC_BITS_DEF = 16;
	localparam int MASS_FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int SUM_W = 64;

	// Datapath widths: r2 < 2^66, floor(sqrt(r2)) < 2^33
	localparam int R2_W = 66;
	localparam int ROOT_W = 33;
	localparam int NUM_W = 80;
	localparam int NUM_HI_W = NUM_W - SUM_W;

	// Serial unit lengths, two result bits per cycle
	localparam int SQ_CYCLES = 18;
	localparam int DIV_CYCLES = 32;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_LOC_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOC_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOC_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOFTENING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAV_CONST = 3'd4;

	localparam logic [COORD_W-1:0] GRAV_RESET = 32'h0001_0000;

	// One particle
	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [COORD_W-1:0]        mass;
		logic                      last;
	} sps_in_t;

	// One result
	typedef struct packed {
		logic signed [SUM_W-1:0] potential;
		logic                    saturated;
	} sps_out_t;

endpackage

/* hdl/sps_isqrt.sv */
// Digit-serial integer square root, two root bits per cycle.
module sps_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sps_pkg::R2_W-1:0]    radicand,
	output logic                        done,
	output logic [sps_pkg::ROOT_W-1:0]  root
);

	localparam int RAD_W = 4 * sps_pkg::SQ_CYCLES;
	localparam int RQ_W = 2 * sps_pkg::SQ_CYCLES;
	localparam int REM_W = RQ_W + 2;
	localparam int CNT_W = $clog2(sps_pkg::SQ_CYCLES);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [RQ_W-1:0]  root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W-1:0] rem_a, trial_a, rem_a2, rem_b, trial_b, rem_b2;
	logic [RQ_W-1:0]  root_a, root_b;
	logic             ge_a, ge_b;

	// Two restoring steps per cycle, each bringing down one bit pair
	always_comb begin
		rem_a   = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial_a = {root_q, 2'b01};
		ge_a    = rem_a >= trial_a;
		rem_a2  = ge_a ? rem_a - trial_a : rem_a;
		root_a  = {root_q[RQ_W-2:0], ge_a};
		rem_b   = {rem_a2[REM_W-3:0], rad_q[RAD_W-3 -: 2]};
		trial_b = {root_a, 2'b01};
		ge_b    = rem_b >= trial_b;
		rem_b2  = ge_b ? rem_b - trial_b : rem_b;
		root_b  = {root_a[RQ_W-2:0], ge_b};
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(sps_pkg::SQ_CYCLES - 1);
			end else if (busy_q) begin
				if (cnt_q == '0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(radicand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-5:0], 4'b0};
			rem_q  <= rem_b2;
			root_q <= root_b;
		end
	end

	assign done = done_q;
	assign root = root_q[sps_pkg::ROOT_W-1:0];

endmodule

/* hdl/sps_div.sv */
// Digit-serial restoring divider, 64 quotient bits at two bits per cycle.
module sps_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [sps_pkg::NUM_HI_W-1:0] num_hi,
	input  logic [sps_pkg::SUM_W-1:0]    num_lo,
	input  logic [sps_pkg::ROOT_W-1:0]   divisor,
	output logic                         done,
	output logic [sps_pkg::SUM_W-1:0]    quot
);

	localparam int DW = sps_pkg::ROOT_W;
	localparam int QW = sps_pkg::SUM_W;
	localparam int CNT_W = $clog2(sps_pkg::DIV_CYCLES);

	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [QW-1:0]    q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DW:0]   d_a, d_b, s_a, s_b;
	logic [DW-1:0] r_a, r_b;
	logic          ge_a, ge_b;

	// Two steps per cycle; the remainder always stays below the divisor
	always_comb begin
		d_a  = {rem_q, q_q[QW-1]};
		s_a  = d_a - {1'b0, den_q};
		ge_a = d_a >= {1'b0, den_q};
		r_a  = ge_a ? s_a[DW-1:0] : d_a[DW-1:0];
		d_b  = {r_a, q_q[QW-2]};
		s_b  = d_b - {1'b0, den_q};
		ge_b = d_b >= {1'b0, den_q};
		r_b  = ge_b ? s_b[DW-1:0] : d_b[DW-1:0];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(sps_pkg::DIV_CYCLES - 1);
			end else if (busy_q) begin
				if (cnt_q == '0)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Dividend bits shift out of the top as quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= divisor;
			rem_q <= DW'(num_hi);
			q_q   <= num_lo;
		end else if (busy_q) begin
			rem_q <= r_b;
			q_q   <= {q_q[QW-3:0], ge_a, ge_b};
		end
	end

	assign done = done_q;
	assign quot = q_q;

endmodule

/* hdl/softened_potential_sum.sv */
// Top level: Plummer-softened direct-sum potential at one configured point.
//
//  channel | signals                           | payload
//  --------+-----------------------------------+------------------------------
//  in      | in_valid / in_ready / in_item     | pos_x, pos_y, pos_z, mass, last
//  cfg     | cfg_valid / cfg_ready             | cfg_index, cfg_data (32 bit)
//  out     | out_valid / out_ready / out_item  | potential (Q32.32), saturated
//
// A particle passes from acceptance to the next free input slot through the
// shared 32x32 multiplier to form r^2, the square root (18 steps of two bits)
// and the divider (32 steps of two bits), then the accumulate. A zero
// distance or oversized term skips the divider. The last particle of a set
// also forms G * sum through the same multiplier.
// Reset clears the sum, the flag and the registers (G to 1.0). The result sits
// in an output register; a stalled output holds only the final stage.
module softened_potential_sum #(
	parameter int COORD_FRAC_BITS = sps_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  sps_pkg::sps_in_t                in_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sps_pkg::COORD_W-1:0]     cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sps_pkg::sps_out_t               out_item
);

	localparam int CW = sps_pkg::COORD_W;
	localparam int SW = sps_pkg::SUM_W;
	localparam int NUM_SHIFT = COORD_FRAC_BITS + 32 - sps_pkg::MASS_FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQR  = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_ACC  = 3'd4;
	localparam logic [2:0] ST_MUL0 = 3'd5;
	localparam logic [2:0] ST_MUL1 = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	localparam logic [2:0] PH_LAST_OP  = 3'd3;
	localparam logic [2:0] PH_LAST_ACC = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;

	// Configuration registers
	logic [CW-1:0] loc_x_q, loc_y_q, loc_z_q, soft_q, grav_q;

	// Control and datapath registers
	logic [2:0]                  state_q;
	logic [2:0]                  phase_q;
	sps_pkg::sps_in_t            item_q;
	logic [CW-1:0]               op_q;
	logic [SW-1:0]               prod_q;
	logic [SW-1:0]               lo_q;
	logic [sps_pkg::R2_W-1:0]    r2_q;
	logic [SW-1:0]               term_q;
	logic                        ovf_q;
	logic [SW-1:0]               sum_q;
	logic                        flag_q;
	logic                        out_valid_q;
	sps_pkg::sps_out_t           out_q;

	// Combinational signals
	logic [CW-1:0]                 op_a, op_b, abs_d;
	logic [CW:0]                   diff;
	logic [CW-1:0]                 mul_a, mul_b;
	logic [SW-1:0]                 mul_p;
	logic [sps_pkg::NUM_W-1:0]     num;
	logic                          sq_start, sq_done;
	logic [sps_pkg::ROOT_W-1:0]    sq_root;
	logic                          dv_start, dv_done;
	logic [SW-1:0]                 dv_quot;
	logic                          term_sat;
	logic [SW:0]                   acc;
	logic [SW+CW-1:0]              gprod;
	logic [SW+CW-17:0]             mag_full;
	logic                          clamp;
	logic [SW-1:0]                 mag;
	logic                          out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign out_free  = !out_valid_q || out_ready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_x_q <= '0;
			loc_y_q <= '0;
			loc_z_q <= '0;
			soft_q  <= '0;
			grav_q  <= sps_pkg::GRAV_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sps_pkg::REG_LOC_X:      loc_x_q <= cfg_data;
				sps_pkg::REG_LOC_Y:      loc_y_q <= cfg_data;
				sps_pkg::REG_LOC_Z:      loc_z_q <= cfg_data;
				sps_pkg::REG_SOFTENING:  soft_q  <= cfg_data;
				sps_pkg::REG_GRAV_CONST: grav_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Magnitude of one displacement component, or the softening length
	always_comb begin
		unique case (phase_q[1:0])
			2'd0: begin op_a = item_q.pos_x; op_b = loc_x_q; end
			2'd1: begin op_a = item_q.pos_y; op_b = loc_y_q; end
			2'd2: begin op_a = item_q.pos_z; op_b = loc_z_q; end
			default: begin op_a = soft_q; op_b = '0; end
		endcase
		diff = {op_a[CW-1], op_a} - {op_b[CW-1], op_b};
		if (phase_q[1:0] == PH_LAST_OP[1:0])
			abs_d = soft_q;
		else if (diff[CW])
			abs_d = CW'((CW+1)'(0) - diff);
		else
			abs_d = diff[CW-1:0];
	end

	// Shared multiplier: squares, then the two halves of G * sum
	always_comb begin
		if (state_q == ST_SQR) begin
			mul_a = op_q;
			mul_b = op_q;
		end else if (state_q == ST_MUL0) begin
			mul_a = sum_q[CW-1:0];
			mul_b = grav_q;
		end else begin
			mul_a = sum_q[SW-1:CW];
			mul_b = grav_q;
		end
	end
	assign mul_p = mul_a * mul_b;

	// Numerator mass * 2^(frac+16); term overflows when its high part reaches r
	assign num      = sps_pkg::NUM_W'(item_q.mass) << NUM_SHIFT;
	assign term_sat = (sq_root == '0) ||
		({{(sps_pkg::ROOT_W-sps_pkg::NUM_HI_W){1'b0}}, num[sps_pkg::NUM_W-1:SW]} >= sq_root);

	assign sq_start = (state_q == ST_SQR) && (phase_q == PH_DONE);
	assign dv_start = (state_q == ST_ROOT) && sq_done && !term_sat;

	sps_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (r2_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	sps_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dv_start),
		.num_hi  (num[sps_pkg::NUM_W-1:SW]),
		.num_lo  (num[SW-1:0]),
		.divisor (sq_root),
		.done    (dv_done),
		.quot    (dv_quot)
	);

	// Saturating accumulate and the final scaling by G
	assign acc      = {1'b0, sum_q} + {1'b0, term_q};
	assign gprod    = {prod_q, {CW{1'b0}}} + {{CW{1'b0}}, lo_q};
	assign mag_full = gprod[SW+CW-1:16];
	assign clamp    = mag_full > {{(CW-16){1'b0}}, 1'b1, {(SW-1){1'b0}}};
	assign mag      = clamp ? {1'b1, {(SW-1){1'b0}}} : mag_full[SW-1:0];

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= '0;
			sum_q       <= '0;
			flag_q      <= 1'b0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Output register: set on emission, cleared once taken
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						phase_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == PH_DONE)
						state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (sq_done) begin
						if (term_sat) begin
							ovf_q   <= 1'b1;
							state_q <= ST_ACC;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (dv_done)
						state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q   <= acc[SW] ? '1 : acc[SW-1:0];
					flag_q  <= flag_q | ovf_q | acc[SW];
					state_q <= item_q.last ? ST_MUL0 : ST_IDLE;
				end
				ST_MUL0: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						sum_q   <= '0;
						flag_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_item;
			r2_q   <= '0;
		end
		if (state_q == ST_SQR) begin
			if (phase_q <= PH_LAST_OP)
				op_q <= abs_d;
			if (phase_q != '0 && phase_q <= PH_LAST_OP + 3'd1)
				prod_q <= mul_p;
			if (phase_q >= 3'd2 && phase_q <= PH_LAST_ACC)
				r2_q <= r2_q + sps_pkg::R2_W'(prod_q);
		end
		if (state_q == ST_ROOT && sq_done && term_sat)
			term_q <= '1;
		if (state_q == ST_DIV && dv_done)
			term_q <= dv_quot;
		if (state_q == ST_MUL0)
			prod_q <= mul_p;
		if (state_q == ST_MUL1) begin
			lo_q   <= prod_q;
			prod_q <= mul_p;
		end
		if (state_q == ST_FIN && out_free) begin
			out_q.potential <= SW'(0) - mag;
			out_q.saturated <= flag_q | clamp;
		end
	end

endmodule
